// ===== hdl/icmp_echo_reply_header_builder_assert.svh =====
// Assertion macros used by the echo reply header builder sequencer.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ICMP_ECHO_REPLY_HEADER_BUILDER_ASSERT_SVH
`define ICMP_ECHO_REPLY_HEADER_BUILDER_ASSERT_SVH

// same-cycle implication
`define ICMPERH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icmperh: assertion failed");

// next-cycle implication
`define ICMPERH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icmperh: assertion failed");

`endif

// ===== hdl/icmperh_pkg.sv =====
// Package for the echo reply header builder: constants, codes, control
// structs and the microcode ROM. No dependencies.
package icmperh_pkg;

  localparam int HEADER_BYTES = 42;
  localparam int MAC_BYTES    = 6;
  localparam int POS_W        = $clog2(HEADER_BYTES);
  localparam int PC_W         = $clog2(HEADER_BYTES + 2);

  localparam int OFS_ETYPE   = 12;
  localparam int OFS_IPPROTO = 23;
  localparam int OFS_IPSRC   = 26;
  localparam int OFS_IPDST   = 30;
  localparam int OFS_ICMP    = 34;

  localparam logic [7:0] ETYPE_HI       = 8'h08;
  localparam logic [7:0] ETYPE_LO       = 8'h00;
  localparam logic [7:0] ICMP_PROTO_NUM = 8'd1;
  localparam logic [7:0] TYPE_ECHO_REQ  = 8'd8;
  localparam logic [7:0] TYPE_ECHO_REP  = 8'd0;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_IPV4 = 3'd1;
  localparam logic [2:0] ST_NOT_ICMP = 3'd2;
  localparam logic [2:0] ST_NOT_ECHO = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(HEADER_BYTES - 1);
  localparam logic [PC_W-1:0]  PC_STATUS = PC_W'(HEADER_BYTES);
  localparam logic [PC_W-1:0]  PC_RECV   = PC_W'(HEADER_BYTES + 1);

  typedef enum logic [1:0] {
    MC_EMIT,
    MC_EMIT_END,
    MC_RECV,
    MC_TRAP
  } mc_kind_e;

  typedef enum logic [2:0] {
    SEL_RAM,
    SEL_ETH_HI,
    SEL_ZERO,
    SEL_CK_HI,
    SEL_CK_LO,
    SEL_STATUS
  } sel_e;

  typedef struct packed {
    mc_kind_e         kind;
    sel_e             sel;
    logic [POS_W-1:0] raddr;
    logic             last;
  } mc_word_t;

  typedef struct packed {
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             issue;
    logic [POS_W-1:0] rd_addr;
    sel_e             sel;
    logic             last;
    logic [2:0]       status;
  } icmperh_ctl_t;

  typedef struct packed {
    logic       go;
    logic [2:0] hdr_status;
  } icmperh_fb_t;

  // Steps 0..41 emit the reply header, step 42 emits a status beat,
  // step 43 takes frame bytes.
  function automatic mc_word_t mc_rom(input logic [PC_W-1:0] pc);
    mc_word_t w;
    int       i;
    i       = int'(pc);
    w.kind  = MC_TRAP;
    w.sel   = SEL_ZERO;
    w.raddr = '0;
    w.last  = 1'b0;
    if (i < HEADER_BYTES) begin
      w.kind  = (i == HEADER_BYTES - 1) ? MC_EMIT_END : MC_EMIT;
      w.last  = (i == HEADER_BYTES - 1);
      w.sel   = SEL_RAM;
      w.raddr = POS_W'(i);
      if (i < MAC_BYTES) begin
        w.raddr = POS_W'(i + MAC_BYTES);
      end else if (i < 2 * MAC_BYTES) begin
        w.raddr = POS_W'(i - MAC_BYTES);
      end else if (i == OFS_ETYPE) begin
        w.sel = SEL_ETH_HI;
      end else if (i == OFS_ETYPE + 1) begin
        w.sel = SEL_ZERO;
      end else if (i >= OFS_IPSRC && i < OFS_IPSRC + 4) begin
        w.raddr = POS_W'(i + 4);
      end else if (i >= OFS_IPDST && i < OFS_IPDST + 4) begin
        w.raddr = POS_W'(i - 4);
      end else if (i == OFS_ICMP) begin
        w.sel = SEL_ZERO;
      end else if (i == OFS_ICMP + 2) begin
        w.sel = SEL_CK_HI;
      end else if (i == OFS_ICMP + 3) begin
        w.sel = SEL_CK_LO;
      end
    end else if (i == HEADER_BYTES) begin
      w.kind = MC_EMIT_END;
      w.sel  = SEL_STATUS;
      w.last = 1'b1;
    end else if (i == HEADER_BYTES + 1) begin
      w.kind = MC_RECV;
    end
    return w;
  endfunction

endpackage

// ===== hdl/icmperh_if.sv =====
// Valid/ready channel interfaces for frame bytes in and reply beats out.
// No dependencies.
interface icmperh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface icmperh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       run_last;
  logic [2:0] status;

  modport source (output valid, output reply_byte, output run_last, output status,
                  input ready);
  modport sink (input valid, input reply_byte, input run_last, input status,
                output ready);
endinterface

// ===== hdl/icmp_echo_reply_header_builder.sv =====
// Path: a reply or status beat goes from the step that issues it through the pending register
// and then the output register; the first beat follows the frame's 42nd byte, then 1 beat/cycle
// while the output is ready. Throughput: 1 frame byte per cycle while receiving; intake pauses
// for the 42-step reply program or 1 step for a status beat.
// Reset: asynchronous, active low; sets the step counter to the receive step and clears the byte
// position, drop flag and beat valids. The header store is not cleared and needs no clearing pass.
module icmp_echo_reply_header_builder
  import icmperh_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  icmperh_in_if.sink    frame_i,
  icmperh_out_if.source reply_o
);

  icmperh_ctl_t ctl;
  icmperh_fb_t  fb;

  icmperh_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_i),
    .fb_i    (fb),
    .ctl_o   (ctl)
  );

  icmperh_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .fb_o    (fb),
    .reply_o (reply_o)
  );

endmodule

// ===== hdl/icmperh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icmperh_ram #(
  parameter int Width = 8,
  parameter int Depth = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/icmperh_seq.sv =====
// Microcode sequencer: step counter, ROM lookup, frame byte intake and
// header checks bookkeeping. Depends on icmperh_pkg, icmperh_in_if and the assertion header.
`include "icmp_echo_reply_header_builder_assert.svh"

module icmperh_seq
  import icmperh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  icmperh_in_if.sink   frame_i,
  input  icmperh_fb_t  fb_i,
  output icmperh_ctl_t ctl_o
);

  logic [PC_W-1:0]  pc_q, pc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             skip_q, skip_d;
  logic [2:0]       st_q, st_d;
  mc_word_t         word;
  logic             acc, issue, take, hdr_done;

  assign word     = mc_rom(pc_q);
  assign frame_i.ready = (word.kind == MC_RECV);
  assign acc      = frame_i.valid && frame_i.ready;
  assign take     = acc && !skip_q;
  assign hdr_done = take && (pos_q == LAST_POS);
  assign issue    = ((word.kind == MC_EMIT) || (word.kind == MC_EMIT_END)) && fb_i.go;

  always_comb begin
    pc_d   = pc_q;
    pos_d  = pos_q;
    skip_d = skip_q;
    st_d   = st_q;
    unique case (word.kind)
      MC_EMIT: begin
        if (issue) pc_d = pc_q + PC_W'(1);
      end
      MC_EMIT_END: begin
        if (issue) pc_d = PC_RECV;
      end
      MC_RECV: begin
        if (acc && skip_q) begin
          if (frame_i.frame_last) begin
            skip_d = 1'b0;
            pos_d  = '0;
          end
        end else if (hdr_done) begin
          pos_d  = '0;
          skip_d = !frame_i.frame_last;
          st_d   = fb_i.hdr_status;
          pc_d   = (fb_i.hdr_status == ST_OK) ? '0 : PC_STATUS;
        end else if (take) begin
          if (frame_i.frame_last) begin
            pos_d = '0;
            st_d  = ST_SHORT;
            pc_d  = PC_STATUS;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      default: pc_d = PC_RECV;
    endcase
  end

  always_comb begin
    ctl_o.wr_en   = take;
    ctl_o.wr_addr = pos_q;
    ctl_o.wr_data = frame_i.frame_byte;
    ctl_o.issue   = issue;
    ctl_o.rd_addr = word.raddr;
    ctl_o.sel     = word.sel;
    ctl_o.last    = word.last;
    ctl_o.status  = st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PC_RECV;
      pos_q  <= '0;
      skip_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      pos_q  <= pos_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  `ICMPERH_ASSERT_IMPL(a_skip_pos, skip_q, pos_q == '0)
  `ICMPERH_ASSERT_IMPL(a_pos_range, 1'b1, pos_q <= LAST_POS)
  `ICMPERH_ASSERT_NEXT(a_end_recv, issue && (word.kind == MC_EMIT_END), pc_q == PC_RECV)
  `ICMPERH_ASSERT_NEXT(a_short, take && frame_i.frame_last && (pos_q != LAST_POS),
                       (pc_q == PC_STATUS) && (st_q == ST_SHORT))

endmodule

// ===== hdl/icmperh_dp.sv =====
// Datapath: header store RAM, captured check bytes, checksum update,
// read pipeline and output register. Depends on icmperh_pkg, icmperh_ram and icmperh_out_if.
module icmperh_dp
  import icmperh_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  icmperh_ctl_t  ctl_i,
  output icmperh_fb_t   fb_o,
  icmperh_out_if.source reply_o
);

  logic [7:0]  rdata;
  logic [7:0]  et_hi_q, et_lo_q, proto_q, type_q, code_q, hc_hi_q, hc_lo_q;
  logic [15:0] ck_q;
  logic [15:0] hc_inv, m_inv;
  logic [17:0] sum0;
  logic [16:0] sum1;
  logic [15:0] sum2;
  logic        pend_valid_q, pend_valid_d;
  sel_e        pend_sel_q;
  logic        pend_last_q;
  logic [2:0]  pend_st_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q;
  logic [2:0]  out_st_q;
  logic        load;

  icmperh_ram #(
    .Width (8),
    .Depth (HEADER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (ctl_i.wr_addr),
    .wdata_i (ctl_i.wr_data),
    .re_i    (ctl_i.issue),
    .raddr_i (ctl_i.rd_addr),
    .rdata_o (rdata)
  );

  // grab the bytes the checks and checksum need as they fly past
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      if (ctl_i.wr_addr == POS_W'(OFS_ETYPE))     et_hi_q <= ctl_i.wr_data;
      if (ctl_i.wr_addr == POS_W'(OFS_ETYPE + 1)) et_lo_q <= ctl_i.wr_data;
      if (ctl_i.wr_addr == POS_W'(OFS_IPPROTO))   proto_q <= ctl_i.wr_data;
      if (ctl_i.wr_addr == POS_W'(OFS_ICMP))      type_q  <= ctl_i.wr_data;
      if (ctl_i.wr_addr == POS_W'(OFS_ICMP + 1))  code_q  <= ctl_i.wr_data;
      if (ctl_i.wr_addr == POS_W'(OFS_ICMP + 2))  hc_hi_q <= ctl_i.wr_data;
      if (ctl_i.wr_addr == POS_W'(OFS_ICMP + 3))  hc_lo_q <= ctl_i.wr_data;
    end
  end

  assign load = pend_valid_q && (!out_valid_q || reply_o.ready);

  always_comb begin
    fb_o.go = !pend_valid_q || load;
    priority if (et_hi_q != ETYPE_HI || et_lo_q != ETYPE_LO) begin
      fb_o.hdr_status = ST_NOT_IPV4;
    end else if (proto_q != ICMP_PROTO_NUM) begin
      fb_o.hdr_status = ST_NOT_ICMP;
    end else if (type_q != TYPE_ECHO_REQ) begin
      fb_o.hdr_status = ST_NOT_ECHO;
    end else begin
      fb_o.hdr_status = ST_OK;
    end
  end

  // incremental update: ~(~HC + ~m + m'), ones' complement
  always_comb begin
    hc_inv = ~{hc_hi_q, hc_lo_q};
    m_inv  = ~{type_q, code_q};
    sum0   = 18'(hc_inv) + 18'(m_inv) + 18'({TYPE_ECHO_REP, code_q});
    sum1   = 17'(sum0[15:0]) + 17'(sum0[17:16]);
    sum2   = sum1[15:0] + 16'(sum1[16]);
  end

  always_ff @(posedge clk_i) begin
    ck_q <= ~sum2;
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (ctl_i.issue) begin
      pend_valid_d = 1'b1;
    end else if (load) begin
      pend_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (reply_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    unique case (pend_sel_q)
      SEL_RAM:    out_byte_d = rdata;
      SEL_ETH_HI: out_byte_d = ETYPE_HI;
      SEL_CK_HI:  out_byte_d = ck_q[15:8];
      SEL_CK_LO:  out_byte_d = ck_q[7:0];
      default:    out_byte_d = TYPE_ECHO_REP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      pend_sel_q  <= ctl_i.sel;
      pend_last_q <= ctl_i.last;
      pend_st_q   <= (ctl_i.sel == SEL_STATUS) ? ctl_i.status : ST_OK;
    end
    if (load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= pend_last_q;
      out_st_q   <= pend_st_q;
    end
  end

  assign reply_o.valid      = out_valid_q;
  assign reply_o.reply_byte = out_byte_q;
  assign reply_o.run_last   = out_last_q;
  assign reply_o.status     = out_st_q;

endmodule
